// ===== rtl/tpss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tpss_pkg
// shared widths, payload types and helpers of the slice segment core
// ============================================================================
package tpss_pkg;

    localparam int CW       = 32;          // coordinate width
    localparam int DW       = CW + 1;      // height difference / edge delta width
    localparam int NW       = 2 * CW;      // interpolation numerator width
    localparam int QW       = CW;          // quotient bits, one per divider stage
    localparam int TW       = 16;          // dedup tolerance width
    localparam int LANES    = 4;           // p0 x, p0 z, p1 x, p1 z
    localparam int LANE_LAT = QW + 2;      // load stage, divider stages, final add

    localparam logic [TW-1:0] TOL_RESET = TW'(1);

    // lane numbering
    localparam int LANE_P0X = 0;
    localparam int LANE_P0Z = 1;
    localparam int LANE_P1X = 2;
    localparam int LANE_P1Z = 3;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord a_x;
        t_coord a_y;
        t_coord a_z;
        t_coord b_x;
        t_coord b_y;
        t_coord b_z;
        t_coord c_x;
        t_coord c_y;
        t_coord c_z;
        t_coord plane_height;
    } t_tri;

    typedef struct packed {
        logic   seg_valid;
        t_coord p0_x;
        t_coord p0_z;
        t_coord p1_x;
        t_coord p1_z;
    } t_seg;

    // one interpolation job: base +/- num / den
    typedef struct packed {
        logic [NW-1:0] num;
        logic [DW-1:0] den;
        t_coord        base;
        logic          neg;
    } t_lane_req;

    // one divider stage: partial remainder, unshifted numerator bits, quotient
    typedef struct packed {
        logic [CW:0]   rem;
        logic [CW-1:0] low;
        logic [DW-1:0] den;
        logic [QW-1:0] q;
        t_coord        base;
        logic          neg;
    } t_div_st;

    // magnitude of a two's complement value one bit wider than a coordinate
    function automatic logic [CW-1:0] mag_d(input logic [DW-1:0] v);
        logic [DW-1:0] n;
        n = v[DW-1] ? (~v + DW'(1)) : v;
        return n[CW-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tpss_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tpss channel interfaces
// valid / ready channels for triangle words, segment words and config writes
// ============================================================================
interface tpss_tri_if;
    logic              valid;
    logic              ready;
    tpss_pkg::t_tri    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tpss_seg_if;
    logic              valid;
    logic              ready;
    tpss_pkg::t_seg    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tpss_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [tpss_pkg::TW-1:0]   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/tpss_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tpss_front
// height differences, crossing edge selection and interpolation products
// ============================================================================
module tpss_front (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_en,
    input  wire logic                                      i_valid,
    input  wire tpss_pkg::t_tri                            i_tri,
    output logic                                           o_valid,
    output logic                                           o_cross,
    output tpss_pkg::t_lane_req [tpss_pkg::LANES-1:0]      o_req
);

    localparam int CW = tpss_pkg::CW;
    localparam int DW = tpss_pkg::DW;
    localparam int NW = tpss_pkg::NW;

    // stage 1: height differences
    logic                r1_valid;
    logic [DW-1:0]       r1_d [0:2];
    tpss_pkg::t_coord    r1_x [0:2];
    tpss_pkg::t_coord    r1_z [0:2];

    // stage 2: magnitudes and denominators
    logic                r2_valid;
    logic                r2_cross;
    logic [CW-1:0]       r2_mda  [0:1];
    logic [DW-1:0]       r2_den  [0:1];
    logic [CW-1:0]       r2_mdel [0:3];
    tpss_pkg::t_coord    r2_base [0:3];
    logic                r2_neg  [0:3];

    // stage 3: products
    logic                r3_valid;
    logic                r3_cross;
    logic [NW-1:0]       r3_num  [0:3];
    logic [DW-1:0]       r3_den  [0:1];
    tpss_pkg::t_coord    r3_base [0:3];
    logic                r3_neg  [0:3];

    logic                w_c_ab, w_c_bc, w_c_ca, w_use_bc;
    logic [DW-1:0]       w_da [0:1];
    logic [DW-1:0]       w_db [0:1];
    tpss_pkg::t_coord    w_va [0:3];
    tpss_pkg::t_coord    w_vb [0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_d[0] <= {i_tri.a_y[CW-1], i_tri.a_y}
                     - {i_tri.plane_height[CW-1], i_tri.plane_height};
            r1_d[1] <= {i_tri.b_y[CW-1], i_tri.b_y}
                     - {i_tri.plane_height[CW-1], i_tri.plane_height};
            r1_d[2] <= {i_tri.c_y[CW-1], i_tri.c_y}
                     - {i_tri.plane_height[CW-1], i_tri.plane_height};
            r1_x[0] <= i_tri.a_x;
            r1_x[1] <= i_tri.b_x;
            r1_x[2] <= i_tri.c_x;
            r1_z[0] <= i_tri.a_z;
            r1_z[1] <= i_tri.b_z;
            r1_z[2] <= i_tri.c_z;
        end
    end

    // crossing edges come in pairs; first is ab if it crosses, else bc
    always_comb begin
        w_c_ab   = r1_d[0][DW-1] ^ r1_d[1][DW-1];
        w_c_bc   = r1_d[1][DW-1] ^ r1_d[2][DW-1];
        w_c_ca   = r1_d[2][DW-1] ^ r1_d[0][DW-1];
        w_use_bc = w_c_ab && w_c_bc;
        w_da[0]  = w_c_ab ? r1_d[0] : r1_d[1];
        w_db[0]  = w_c_ab ? r1_d[1] : r1_d[2];
        w_da[1]  = w_use_bc ? r1_d[1] : r1_d[2];
        w_db[1]  = w_use_bc ? r1_d[2] : r1_d[0];
        w_va[tpss_pkg::LANE_P0X] = w_c_ab ? r1_x[0] : r1_x[1];
        w_vb[tpss_pkg::LANE_P0X] = w_c_ab ? r1_x[1] : r1_x[2];
        w_va[tpss_pkg::LANE_P0Z] = w_c_ab ? r1_z[0] : r1_z[1];
        w_vb[tpss_pkg::LANE_P0Z] = w_c_ab ? r1_z[1] : r1_z[2];
        w_va[tpss_pkg::LANE_P1X] = w_use_bc ? r1_x[1] : r1_x[2];
        w_vb[tpss_pkg::LANE_P1X] = w_use_bc ? r1_x[2] : r1_x[0];
        w_va[tpss_pkg::LANE_P1Z] = w_use_bc ? r1_z[1] : r1_z[2];
        w_vb[tpss_pkg::LANE_P1Z] = w_use_bc ? r1_z[2] : r1_z[0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_cross <= w_c_ab | w_c_bc | w_c_ca;
            for (int e = 0; e < 2; e++) begin
                r2_mda[e] <= tpss_pkg::mag_d(w_da[e]);
                r2_den[e] <= {1'b0, tpss_pkg::mag_d(w_da[e])}
                           + {1'b0, tpss_pkg::mag_d(w_db[e])};
            end
        end
    end

    for (genvar k = 0; k < tpss_pkg::LANES; k++) begin : g_lane
        logic [DW-1:0] w_delta;
        assign w_delta = {w_vb[k][CW-1], w_vb[k]} - {w_va[k][CW-1], w_va[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r2_mdel[k] <= tpss_pkg::mag_d(w_delta);
                r2_base[k] <= w_va[k];
                r2_neg[k]  <= w_delta[DW-1];
                r3_num[k]  <= NW'(r2_mda[k/2]) * NW'(r2_mdel[k]);
                r3_base[k] <= r2_base[k];
                r3_neg[k]  <= r2_neg[k];
            end
        end

        assign o_req[k].num  = r3_num[k];
        assign o_req[k].den  = r3_den[k/2];
        assign o_req[k].base = r3_base[k];
        assign o_req[k].neg  = r3_neg[k];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_cross  <= r2_cross;
            r3_den[0] <= r2_den[0];
            r3_den[1] <= r2_den[1];
        end
    end

    assign o_valid = r3_valid;
    assign o_cross = r3_cross;

endmodule
`default_nettype wire

// ===== rtl/tpss_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tpss_div
// one interpolation lane: restoring divider, one quotient bit per stage
// ============================================================================
module tpss_div (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire tpss_pkg::t_lane_req  i_req,
    output tpss_pkg::t_coord          o_coord
);

    localparam int CW = tpss_pkg::CW;
    localparam int QW = tpss_pkg::QW;

    tpss_pkg::t_div_st r_st [0:QW];
    tpss_pkg::t_coord  r_res;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0].rem  <= {1'b0, i_req.num[2*CW-1:CW]};
            r_st[0].low  <= i_req.num[CW-1:0];
            r_st[0].den  <= i_req.den;
            r_st[0].q    <= '0;
            r_st[0].base <= i_req.base;
            r_st[0].neg  <= i_req.neg;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [CW+1:0]     w_trial;
        logic [CW+1:0]     w_diff;
        logic              w_ge;
        tpss_pkg::t_div_st n_st;

        always_comb begin
            w_trial = {r_st[k].rem, r_st[k].low[CW-1]};
            w_diff  = w_trial - {1'b0, r_st[k].den};
            w_ge    = w_trial >= {1'b0, r_st[k].den};
            n_st      = r_st[k];
            n_st.low  = {r_st[k].low[CW-2:0], 1'b0};
            n_st.rem  = w_ge ? w_diff[CW:0] : w_trial[CW:0];
            n_st.q    = {r_st[k].q[QW-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k+1] <= n_st;
            end
        end
    end

    // quotient never exceeds the edge span, so the sum stays in range
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= r_st[QW].neg ? r_st[QW].base - CW'(r_st[QW].q)
                                  : r_st[QW].base + CW'(r_st[QW].q);
        end
    end

    assign o_coord = r_res;

endmodule
`default_nettype wire

// ===== rtl/tpss_dedup.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tpss_dedup
// clears the segment if its second point lies within tolerance of the first
// ============================================================================
module tpss_dedup (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire tpss_pkg::t_seg           i_seg,
    input  wire logic [tpss_pkg::TW-1:0]  i_tol,
    output logic                          o_valid,
    output tpss_pkg::t_seg                o_seg
);

    localparam int CW = tpss_pkg::CW;
    localparam int TW = tpss_pkg::TW;

    logic               r1_valid;
    tpss_pkg::t_seg     r1_seg;
    logic [CW-1:0]      r1_dx, r1_dz;

    logic               r2_valid;
    tpss_pkg::t_seg     r2_seg;
    logic               r2_far;
    logic [2*TW-1:0]    r2_sqx, r2_sqz, r2_tsq;

    logic               w_near;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_seg <= i_seg;
            r1_dx  <= tpss_pkg::mag_d({i_seg.p0_x[CW-1], i_seg.p0_x}
                                    - {i_seg.p1_x[CW-1], i_seg.p1_x});
            r1_dz  <= tpss_pkg::mag_d({i_seg.p0_z[CW-1], i_seg.p0_z}
                                    - {i_seg.p1_z[CW-1], i_seg.p1_z});
            r2_seg <= r1_seg;
            r2_far <= (r1_dx > CW'(i_tol)) || (r1_dz > CW'(i_tol));
            r2_sqx <= (2*TW)'(r1_dx[TW-1:0]) * (2*TW)'(r1_dx[TW-1:0]);
            r2_sqz <= (2*TW)'(r1_dz[TW-1:0]) * (2*TW)'(r1_dz[TW-1:0]);
            r2_tsq <= (2*TW)'(i_tol) * (2*TW)'(i_tol);
        end
    end

    always_comb begin
        w_near = !r2_far
              && (({1'b0, r2_sqx} + {1'b0, r2_sqz}) <= {1'b0, r2_tsq});
        o_seg.seg_valid = r2_seg.seg_valid && !w_near;
        o_seg.p0_x = o_seg.seg_valid ? r2_seg.p0_x : '0;
        o_seg.p0_z = o_seg.seg_valid ? r2_seg.p0_z : '0;
        o_seg.p1_x = o_seg.seg_valid ? r2_seg.p1_x : '0;
        o_seg.p1_z = o_seg.seg_valid ? r2_seg.p1_z : '0;
    end

    assign o_valid = r2_valid;

endmodule
`default_nettype wire

// ===== rtl/triangle_plane_slice_segment_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// triangle_plane_slice_segment_core
// slices one triangle per word against a horizontal plane
// ============================================================================
// takes one triangle word per clock and returns one segment word per triangle,
// in order, through 3 front stages (height differences, edge selection,
// 32x32 products), the four interpolation lanes (load, 32 restoring
// divider stages at one quotient bit each, final add), 2 dedup stages
// and the output register. throughput is one word per clock;
// the whole pipeline advances together and holds while a finished segment
// waits on a low ready, so a stall drops and repeats nothing. the dedup
// tolerance register resets to 1 and is written through the config channel,
// which is always ready; write it only while the core is empty.
// ============================================================================
module triangle_plane_slice_segment_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tpss_tri_if.sink    i_tri,
    tpss_cfg_if.sink    i_cfg,
    tpss_seg_if.source  o_seg
);

    localparam int LAT = tpss_pkg::LANE_LAT;

    logic                                         w_adv;
    logic [tpss_pkg::TW-1:0]                      r_tol;

    // front end outputs
    logic                                         w_fr_valid;
    logic                                         w_fr_cross;
    tpss_pkg::t_lane_req [tpss_pkg::LANES-1:0]    w_req;

    // valid and crossing flag ride alongside the lanes
    logic [LAT-1:0]                               r_vld_line;
    logic [LAT-1:0]                               r_crs_line;
    tpss_pkg::t_coord                             w_coord [0:tpss_pkg::LANES-1];

    tpss_pkg::t_seg                               w_pts;
    logic                                         w_dd_valid;
    tpss_pkg::t_seg                               w_dd_seg;

    // output register
    logic                                         r_out_valid;
    tpss_pkg::t_seg                               r_out;

    // whole pipeline moves when the output slot is free or being drained
    assign w_adv       = !r_out_valid || o_seg.ready;
    assign i_tri.ready = w_adv;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= tpss_pkg::TOL_RESET;
        end else if (i_cfg.valid) begin
            r_tol <= i_cfg.data;
        end
    end

    tpss_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_tri.valid),
        .i_tri   (i_tri.data),
        .o_valid (w_fr_valid),
        .o_cross (w_fr_cross),
        .o_req   (w_req)
    );

    for (genvar k = 0; k < tpss_pkg::LANES; k++) begin : g_lane
        tpss_div u_div (
            .i_clk   (i_clk),
            .i_en    (w_adv),
            .i_req   (w_req[k]),
            .o_coord (w_coord[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_line <= '0;
        end else if (w_adv) begin
            r_vld_line <= {r_vld_line[LAT-2:0], w_fr_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_crs_line <= {r_crs_line[LAT-2:0], w_fr_cross};
        end
    end

    // candidate segment, flagged when the triangle crosses the plane at all
    always_comb begin
        w_pts.seg_valid = r_crs_line[LAT-1];
        w_pts.p0_x      = w_coord[tpss_pkg::LANE_P0X];
        w_pts.p0_z      = w_coord[tpss_pkg::LANE_P0Z];
        w_pts.p1_x      = w_coord[tpss_pkg::LANE_P1X];
        w_pts.p1_z      = w_coord[tpss_pkg::LANE_P1Z];
    end

    tpss_dedup u_dedup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_vld_line[LAT-1]),
        .i_seg   (w_pts),
        .i_tol   (r_tol),
        .o_valid (w_dd_valid),
        .o_seg   (w_dd_seg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_dd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_dd_seg;
        end
    end

    assign o_seg.valid = r_out_valid;
    assign o_seg.data  = r_out;

    // a word without a segment carries zero endpoints
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_seg.valid && !o_seg.data.seg_valid) |->
        (o_seg.data.p0_x == '0 && o_seg.data.p0_z == '0 &&
         o_seg.data.p1_x == '0 && o_seg.data.p1_z == '0))
        else $error("segment-less word with nonzero endpoints");

    // a held output freezes the in-flight valid bits
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld_line))
        else $error("valid line moved during a stall");

    // config writes land in the tolerance register
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.valid |=> (r_tol == $past(i_cfg.data)))
        else $error("tolerance register missed a write");

endmodule
`default_nettype wire

// ===== test/triangle_plane_slice_segment_core_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// triangle_plane_slice_segment_core_tb
// checks slice segments against an in-bench predictor under random flow control
// ============================================================================
module triangle_plane_slice_segment_core_tb;

    localparam int CW = tpss_pkg::CW;
    localparam int TW = tpss_pkg::TW;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #2 i_clk = ~i_clk;

    tpss_tri_if tri_ch ();
    tpss_cfg_if cfg_ch ();
    tpss_seg_if seg_ch ();

    triangle_plane_slice_segment_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (tri_ch),
        .i_cfg   (cfg_ch),
        .o_seg   (seg_ch)
    );

    int mismatch_count = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // segment predictor and store of expected segment words
    class seg_scoreboard;
        tpss_pkg::t_seg pending[$];
        logic [TW-1:0] tolerance;

        function new();
            tolerance = tpss_pkg::TOL_RESET;
        endfunction

        // crossing point coordinate: va + trunc(delta*da/(da-db))
        function logic signed [CW-1:0] interp(
                input logic signed [CW:0] va, input logic signed [CW:0] vb,
                input logic signed [CW:0] da, input logic signed [CW:0] db);
            logic signed [CW+1:0] delta;
            logic signed [CW+1:0] den;
            logic [2*CW+3:0] prod;
            logic [2*CW+3:0] q;
            logic [CW+1:0] mden;
            delta = vb - va;
            den = da - db;
            mden = den < 0 ? -den : den;
            prod = (da < 0 ? -da : da) * (delta < 0 ? -delta : delta);
            q = prod / mden;
            return delta < 0 ? CW'(va - q) : CW'(va + q);
        endfunction

        function bit close(input logic signed [CW-1:0] ax,
                input logic signed [CW-1:0] az, input logic signed [CW-1:0] bx,
                input logic signed [CW-1:0] bz);
            logic signed [CW+1:0] dx;
            logic signed [CW+1:0] dz;
            logic [63:0] t;
            dx = ax - bx;
            dz = az - bz;
            if (dx < 0) dx = -dx;
            if (dz < 0) dz = -dz;
            t = tolerance;
            if (dx > t || dz > t) return 0;
            return 64'(dx * dx) + 64'(dz * dz) <= t * t;
        endfunction

        function void note_triangle(input tpss_pkg::t_tri t);
            logic signed [CW:0] vx[3];
            logic signed [CW:0] vz[3];
            logic signed [CW:0] dh[3];
            logic signed [CW-1:0] px[3];
            logic signed [CW-1:0] pz[3];
            logic signed [CW-1:0] x;
            logic signed [CW-1:0] z;
            int n;
            int j;
            tpss_pkg::t_seg s;
            vx[0] = t.a_x; vx[1] = t.b_x; vx[2] = t.c_x;
            vz[0] = t.a_z; vz[1] = t.b_z; vz[2] = t.c_z;
            dh[0] = $signed({t.a_y[CW-1], t.a_y}) - t.plane_height;
            dh[1] = $signed({t.b_y[CW-1], t.b_y}) - t.plane_height;
            dh[2] = $signed({t.c_y[CW-1], t.c_y}) - t.plane_height;
            n = 0;
            for (int i = 0; i < 3; i++) begin
                j = (i == 2) ? 0 : i + 1;
                if ((dh[i] >= 0) != (dh[j] >= 0)) begin
                    x = interp(vx[i], vx[j], dh[i], dh[j]);
                    z = interp(vz[i], vz[j], dh[i], dh[j]);
                    if (n == 0 || !close(px[n-1], pz[n-1], x, z)) begin
                        px[n] = x;
                        pz[n] = z;
                        n++;
                    end
                end
            end
            s = '0;
            if (n == 2) begin
                s.seg_valid = 1'b1;
                s.p0_x = px[0]; s.p0_z = pz[0];
                s.p1_x = px[1]; s.p1_z = pz[1];
            end
            pending = {pending, s};
        endfunction

        task check_segment(input tpss_pkg::t_seg got);
            tpss_pkg::t_seg want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected word", 64'(got.seg_valid), 64'd0);
                return;
            end
            want = pending.pop_front();
            if (got.seg_valid !== want.seg_valid)
                report_mismatch("seg_valid", 64'(got.seg_valid), 64'(want.seg_valid));
            if (got.p0_x !== want.p0_x) report_mismatch("p0_x", 64'(got.p0_x), 64'(want.p0_x));
            if (got.p0_z !== want.p0_z) report_mismatch("p0_z", 64'(got.p0_z), 64'(want.p0_z));
            if (got.p1_x !== want.p1_x) report_mismatch("p1_x", 64'(got.p1_x), 64'(want.p1_x));
            if (got.p1_z !== want.p1_z) report_mismatch("p1_z", 64'(got.p1_z), 64'(want.p1_z));
        endtask
    endclass

    seg_scoreboard sb = new();

    int send_idle_pct = 0;   // percent of cycles the sender sits idle
    int recv_stall_pct = 0;  // percent of cycles the receiver stalls
    int hold_off_cycles = 0; // long receiver hold-off, counted below

    initial begin
        tri_ch.valid = 1'b0;
        tri_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        seg_ch.ready = 1'b0;
    end

    // receiver: ready set at falling edge, word taken at rising edge
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            seg_ch.ready <= 1'b0;
        end else begin
            seg_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && seg_ch.valid && seg_ch.ready)
            sb.check_segment(seg_ch.data);
    end

    // wait for all outstanding segments, then some latency margin
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [TW-1:0] v);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.tolerance = v;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // offer one triangle; valid stays high between back-to-back words
    task automatic send_triangle(input tpss_pkg::t_tri t);
        while ($urandom_range(99) < send_idle_pct) begin
            tri_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        tri_ch.valid <= 1'b1;
        tri_ch.data <= t;
        do @(posedge i_clk); while (!tri_ch.ready);
        sb.note_triangle(t);
        @(negedge i_clk);
    endtask

    task automatic finish_burst();
        tri_ch.valid <= 1'b0;
    endtask

    function automatic tpss_pkg::t_coord rand_coord();
        case ($urandom_range(5))
            0: return tpss_pkg::t_coord'($urandom);
            1: return tpss_pkg::t_coord'($signed($urandom_range(2000)) - 1000);
            2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return tpss_pkg::t_coord'($signed($urandom_range(1 << 22)) - (1 << 21));
        endcase
    endfunction

    // mostly triangles that straddle the plane, rest fully random
    function automatic tpss_pkg::t_tri rand_triangle();
        tpss_pkg::t_tri t;
        t.a_x = rand_coord(); t.a_y = rand_coord(); t.a_z = rand_coord();
        t.b_x = rand_coord(); t.b_y = rand_coord(); t.b_z = rand_coord();
        t.c_x = rand_coord(); t.c_y = rand_coord(); t.c_z = rand_coord();
        t.plane_height = rand_coord();
        if ($urandom_range(3) != 0) begin
            t.plane_height = tpss_pkg::t_coord'($signed($urandom_range(1 << 20)) - (1 << 19));
            t.a_y = t.plane_height + tpss_pkg::t_coord'($urandom_range(1 << 20));
            t.b_y = t.plane_height - tpss_pkg::t_coord'($urandom_range(1 << 20)) - 1;
            t.c_y = $urandom_range(1) ? t.a_y : t.b_y;
            if ($urandom_range(7) == 0) t.c_y = t.plane_height;
        end
        if ($urandom_range(9) == 0) begin
            // near-degenerate: tiny triangle to exercise dedup
            t.b_x = t.a_x + tpss_pkg::t_coord'($urandom_range(3));
            t.c_x = t.a_x - tpss_pkg::t_coord'($urandom_range(3));
            t.b_z = t.a_z + tpss_pkg::t_coord'($urandom_range(3));
            t.c_z = t.a_z;
        end
        return t;
    endfunction

    function automatic tpss_pkg::t_tri mk(input tpss_pkg::t_coord ay,
                                          input tpss_pkg::t_coord by,
                                          input tpss_pkg::t_coord cy,
                                          input tpss_pkg::t_coord h,
                                          input tpss_pkg::t_coord lo,
                                          input tpss_pkg::t_coord hi);
        tpss_pkg::t_tri t;
        t.a_x = lo; t.a_y = ay; t.a_z = hi;
        t.b_x = hi; t.b_y = by; t.b_z = lo;
        t.c_x = lo; t.c_y = cy; t.c_z = lo;
        t.plane_height = h;
        return t;
    endfunction

    localparam tpss_pkg::t_coord MAXC = 32'sh7fffffff;
    localparam tpss_pkg::t_coord MINC = 32'sh80000000;

    initial begin
        tpss_pkg::t_tri t;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, no crossing, vertex on plane, duplicate points
        send_triangle(mk(MAXC, MINC, MAXC, 0, MINC, MAXC));
        send_triangle(mk(MINC, MAXC, MINC, MAXC, MAXC, MINC));
        send_triangle(mk(MAXC, MINC, 0, MINC, MINC, MAXC));
        send_triangle(mk(10, 20, 30, 5, 0, 100));        // all above
        send_triangle(mk(-10, -20, -30, 5, 0, 100));     // all below
        send_triangle(mk(0, -5, 5, 0, -100, 100));       // vertex on plane
        send_triangle(mk(0, 0, 0, 0, 1, 2));             // all on plane
        send_triangle(mk(10, -10, 10, 0, 0, 1));         // close points
        send_triangle(mk(MAXC, MINC, MINC, -1, MAXC, MINC));
        send_triangle(mk(1, -1, 1, 0, MINC, MAXC));
        t = '1;
        send_triangle(t);
        t = '0;
        send_triangle(t);
        t = mk(65536, -65536, 65536, 0, 0, 0);
        t.c_x = 1; t.c_z = 1;
        send_triangle(t);
        finish_burst();
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_tolerance(16'd0);
                1: write_tolerance(16'hffff);
                2: write_tolerance(16'd3);
                3: write_tolerance(16'd1);
                4: write_tolerance(16'($urandom));
                default: write_tolerance(16'd2);
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            if (ph == 2) hold_off_cycles = 200;
            for (int k = 0; k < 80; k++) begin
                send_triangle(rand_triangle());
                if (ph == 4 && k == 40) begin
                    // pause the sender until everything is back
                    finish_burst();
                    while (sb.pending.size() != 0) @(posedge i_clk);
                    @(negedge i_clk);
                end
            end
            finish_burst();
            drain();
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
